// ----- rtl/core/rra_pkg.sv -----
`timescale 1ns / 1ps

package rra_pkg;

	// Width of the address arithmetic: a 32-bit base plus a 32-bit length, a rounded
	// size of up to 2^32 and a boundary step all fit with room to spare.
	localparam int CALC_W = 35;

	typedef enum logic [1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_FLUSH   = 2'd1,
		CMD_RELEASE = 2'd2,
		CMD_QUERY   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		KIND_ALLOC = 3'd0,
		KIND_PURGE = 3'd1,
		KIND_FAIL  = 3'd2,
		KIND_REPLY = 3'd3,
		KIND_DONE  = 3'd4
	} kind_t;

	localparam logic [2:0] REG_START    = 3'd0;
	localparam logic [2:0] REG_END      = 3'd1;
	localparam logic [2:0] REG_ALIGN    = 3'd2;
	localparam logic [2:0] REG_BOUNDARY = 3'd3;
	localparam logic [2:0] REG_BND_EN   = 3'd4;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  slot;
		logic [31:0] addr;
		logic        notify;
		logic        last;
	} result_t;

endpackage

// ----- rtl/core/ring_region_allocator.sv -----
`timescale 1ns / 1ps

// Ring region allocator with oldest-first eviction.
// Input items arrive on s_axis (tuser = command, tdata = request_size and slot_number);
// results leave on m_axis (tuser = kind, tlast = final result of the item). One item
// may produce up to SLOTS+1 results. The user writes configuration through cfg_we /
// cfg_index / cfg_data only while the block is idle; the block does not enforce it.
// Items are handled one at a time: s_axis_tready is high only while the sequencer
// waits for work. Slot base and length live in a single-port-read synchronous
// memory with registered read data; every memory access is its own sequencer
// step, so a read never overlaps a write to the same entry.
// A query or release reads its slot on acceptance and emits from its completion step;
// an allocate adds an eviction read step and a purge step for each eviction, and a
// flush runs those steps for each live block before its done notice.
// Each eviction is a read of the oldest slot followed by a purge notice and a
// write-back that clears it.
// Reset empties the table (live count zero, notify bits clear) and loads the
// register defaults; the memory itself is not cleared.
// When the receiver stalls, the pending result holds in the output register and
// the sequencer waits in its current step.
module ring_region_allocator #(
	parameter int SLOTS     = 16,
	parameter int ADDR_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // request_size[31:0], slot_number[35:32]
	input  logic [1:0]  s_axis_tuser,  // command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // slot_id[3:0], block_address[35:4], notify[36]
	output logic [2:0]  m_axis_tuser,  // kind
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int SW = SLOTS > 1 ? $clog2(SLOTS) : 1;
	localparam int LW = $clog2(SLOTS + 1);
	localparam int CW = rra_pkg::CALC_W;
	localparam logic [31:0] OUT_MASK =
		(ADDR_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_BITS) - 64'd1);

	typedef enum logic [13:0] {
		ST_IDLE  = 14'b00000000000001,
		ST_APREP = 14'b00000000000010,
		ST_ACHK  = 14'b00000000000100,
		ST_NEWR  = 14'b00000000001000,
		ST_NEWC  = 14'b00000000010000,
		ST_BND   = 14'b00000000100000,
		ST_WCHK  = 14'b00000001000000,
		ST_EVR   = 14'b00000010000000,
		ST_EVC   = 14'b00000100000000,
		ST_AWR   = 14'b00001000000000,
		ST_FAIL  = 14'b00010000000000,
		ST_DONE  = 14'b00100000000000,
		ST_RELC  = 14'b01000000000000,
		ST_QRYC  = 14'b10000000000000
	} state_t;

	// What an eviction loop is for, and where it goes when it stops.
	typedef enum logic [1:0] {
		PH_FULL  = 2'd0,
		PH_WRAP  = 2'd1,
		PH_OVL   = 2'd2,
		PH_FLUSH = 2'd3
	} phase_t;

	// configuration
	logic [31:0] start_q, end_q;
	logic [4:0]  ash_q, bsh_q;
	logic        ben_q;

	// sequencer state
	state_t            state_q;
	phase_t            phase_q;
	logic [31:0]       req_q;
	logic [SW-1:0]     sidx_q;
	logic              slot_ok_q;
	logic [3:0]        slot_q;
	logic [CW-1:0]     lo_q, size_q, addr_q;
	logic [SW-1:0]     idx_q, oldest_q, newest_q;
	logic [LW-1:0]     live_q;
	logic [SLOTS-1:0]  notify_q;

	// memory and output
	logic              mem_we, mem_re;
	logic [SW-1:0]     mem_waddr, mem_raddr;
	logic [63:0]       mem_wdata, mem_rdata;
	logic              emit, out_free;
	rra_pkg::result_t  res;

	function automatic logic [SW-1:0] ring_inc(input logic [SW-1:0] s);
		ring_inc = (s == SW'(SLOTS - 1)) ? '0 : s + SW'(1);
	endfunction

	rra_slot_mem #(.SLOTS(SLOTS)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	rra_out_stage u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.emit          (emit),
		.res           (res),
		.free          (out_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// ---------------------------------------------------------------- decode
	logic [7:0]    in_slot_ext, old_ext, idx_ext;
	logic          in_slot_ok;
	logic [31:0]   rd_base, rd_len;
	logic [CW-1:0] base_ext, sum, amask, lo_raw, lo_rnd, sz_raw, sz_rnd;
	logic [CW-1:0] bsz, bmask, end_ext;
	logic          accept, evict_cond;

	assign accept      = s_axis_tvalid && s_axis_tready;
	assign in_slot_ext = {4'b0000, s_axis_tdata[35:32]};
	assign in_slot_ok  = in_slot_ext < 8'(SLOTS);
	assign old_ext     = 8'(oldest_q);
	assign idx_ext     = 8'(idx_q);
	assign rd_base     = mem_rdata[63:32];
	assign rd_len      = mem_rdata[31:0];
	assign base_ext    = CW'(rd_base);
	assign end_ext     = CW'(end_q);
	assign sum         = addr_q + size_q;

	// round start and size up to the alignment
	assign amask  = (CW'(1) << ash_q) - CW'(1);
	assign lo_raw = CW'(start_q);
	assign lo_rnd = ((lo_raw & amask) != '0) ? (lo_raw | amask) + CW'(1) : lo_raw;
	assign sz_raw = CW'(req_q);
	assign sz_rnd = ((sz_raw & amask) != '0) ? (sz_raw | amask) + CW'(1) : sz_raw;

	assign bsz   = CW'(1) << bsh_q;
	assign bmask = ~(bsz - CW'(1));

	always_comb begin
		case (phase_q)
			PH_WRAP: evict_cond = base_ext > addr_q;
			PH_OVL:  evict_cond = (addr_q <= base_ext) && (sum >= base_ext);
			default: evict_cond = 1'b1;
		endcase
	end

	assign s_axis_tready = (state_q == ST_IDLE);

	// ---------------------------------------------------------------- memory and emission
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = oldest_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = oldest_q;
		emit      = 1'b0;
		res       = '{kind: rra_pkg::KIND_ALLOC, slot: 4'd0, addr: 32'd0, notify: 1'b0,
			last: 1'b1};
		case (state_q)
			ST_IDLE: begin
				if (accept && in_slot_ok &&
						(s_axis_tuser == rra_pkg::CMD_RELEASE ||
						s_axis_tuser == rra_pkg::CMD_QUERY)) begin
					mem_re    = 1'b1;
					mem_raddr = in_slot_ext[SW-1:0];
				end
			end
			ST_NEWR: begin
				mem_re    = live_q != '0;
				mem_raddr = newest_q;
			end
			ST_EVR: begin
				mem_re    = live_q != '0;
				mem_raddr = oldest_q;
			end
			ST_EVC: begin
				if (evict_cond && out_free) begin
					mem_we     = 1'b1;
					emit       = 1'b1;
					res.kind   = rra_pkg::KIND_PURGE;
					res.slot   = old_ext[3:0];
					res.addr   = rd_base;
					res.notify = notify_q[oldest_q];
					res.last   = 1'b0;
				end
			end
			ST_AWR: begin
				if (out_free) begin
					mem_we    = 1'b1;
					mem_waddr = idx_q;
					mem_wdata = {addr_q[31:0], size_q[31:0]};
					emit      = 1'b1;
					res.slot  = idx_ext[3:0];
					res.addr  = addr_q[31:0] & OUT_MASK;
				end
			end
			ST_FAIL: begin
				emit     = out_free;
				res.kind = rra_pkg::KIND_FAIL;
			end
			ST_DONE: begin
				emit     = out_free;
				res.kind = rra_pkg::KIND_DONE;
			end
			ST_RELC: begin
				emit       = out_free;
				res.kind   = rra_pkg::KIND_PURGE;
				res.slot   = slot_q;
				res.addr   = rd_base;
				res.notify = notify_q[sidx_q];
			end
			ST_QRYC: begin
				emit     = out_free;
				res.kind = rra_pkg::KIND_REPLY;
				res.slot = slot_q;
				res.addr = slot_ok_q ? rd_base : 32'd0;
			end
			default: begin
			end
		endcase
	end

	// ---------------------------------------------------------------- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 32'd0;
			end_q   <= 32'd65536;
			ash_q   <= 5'd2;
			bsh_q   <= 5'd20;
			ben_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				rra_pkg::REG_START:    start_q <= cfg_data;
				rra_pkg::REG_END:      end_q   <= cfg_data;
				rra_pkg::REG_ALIGN:    ash_q   <= cfg_data[4:0];
				rra_pkg::REG_BOUNDARY: bsh_q   <= cfg_data[4:0];
				rra_pkg::REG_BND_EN:   ben_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			phase_q  <= PH_FLUSH;
			oldest_q <= '0;
			newest_q <= '0;
			live_q   <= '0;
			notify_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						req_q     <= s_axis_tdata[31:0];
						slot_q    <= s_axis_tdata[35:32];
						sidx_q    <= in_slot_ext[SW-1:0];
						slot_ok_q <= in_slot_ok;
						case (s_axis_tuser)
							rra_pkg::CMD_ALLOC: state_q <= ST_APREP;
							rra_pkg::CMD_FLUSH: begin
								phase_q <= PH_FLUSH;
								state_q <= ST_EVR;
							end
							rra_pkg::CMD_RELEASE: state_q <= in_slot_ok ? ST_RELC : ST_IDLE;
							default: state_q <= ST_QRYC;
						endcase
					end
				end
				ST_APREP: begin
					lo_q    <= lo_rnd;
					size_q  <= sz_rnd;
					state_q <= ST_ACHK;
				end
				ST_ACHK: begin
					if (size_q == '0 || (lo_q >> ADDR_BITS) != '0 || lo_q >= end_ext ||
							size_q > end_ext - lo_q) begin
						state_q <= ST_FAIL;
					end else if (live_q >= LW'(SLOTS)) begin
						phase_q <= PH_FULL;
						state_q <= ST_EVR;
					end else begin
						state_q <= ST_NEWR;
					end
				end
				ST_NEWR: begin
					if (live_q != '0) begin
						idx_q   <= ring_inc(newest_q);
						state_q <= ST_NEWC;
					end else begin
						idx_q   <= '0;
						addr_q  <= lo_q;
						phase_q <= PH_OVL;
						state_q <= ST_EVR;
					end
				end
				ST_NEWC: begin
					addr_q  <= CW'(rd_base) + CW'(rd_len);
					state_q <= ST_BND;
				end
				ST_BND: begin
					// move once to the next boundary if the block would span one
					if (ben_q && ((addr_q & bmask) != ((sum - CW'(1)) & bmask))) begin
						addr_q <= (addr_q & bmask) + bsz;
					end
					state_q <= ST_WCHK;
				end
				ST_WCHK: begin
					phase_q <= (sum > end_ext) ? PH_WRAP : PH_OVL;
					state_q <= ST_EVR;
				end
				ST_EVR, ST_EVC: begin
					if ((state_q == ST_EVR && live_q == '0) ||
							(state_q == ST_EVC && !evict_cond)) begin
						// loop finished: advance to what follows this phase
						case (phase_q)
							PH_FLUSH: state_q <= ST_DONE;
							PH_FULL:  state_q <= ST_NEWR;
							PH_WRAP: begin
								addr_q  <= lo_q;
								phase_q <= PH_OVL;
								state_q <= ST_EVR;
							end
							default: state_q <= ST_AWR;
						endcase
					end else if (state_q == ST_EVR) begin
						state_q <= ST_EVC;
					end else if (out_free) begin
						// drop the oldest block
						notify_q[oldest_q] <= 1'b0;
						live_q <= live_q - LW'(1);
						if (live_q == LW'(1)) begin
							oldest_q <= '0;
							newest_q <= '0;
						end else begin
							oldest_q <= ring_inc(oldest_q);
						end
						state_q <= ST_EVR;
					end
				end
				ST_AWR: begin
					if (out_free) begin
						notify_q[idx_q] <= 1'b1;
						if (live_q == '0) begin
							oldest_q <= idx_q;
						end
						newest_q <= idx_q;
						live_q   <= live_q + LW'(1);
						state_q  <= ST_IDLE;
					end
				end
				ST_RELC: begin
					if (out_free) begin
						notify_q[sidx_q] <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				ST_FAIL, ST_DONE, ST_QRYC: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/core/rra_slot_mem.sv -----
`timescale 1ns / 1ps

// Slot table: base in the upper word, length in the lower word.
module rra_slot_mem #(
	parameter int SLOTS = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] waddr,
	input  logic [63:0]                           wdata,
	input  logic                                  re,
	input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] raddr,
	output logic [63:0]                           rdata
);

	logic [63:0] mem [SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/rra_out_stage.sv -----
`timescale 1ns / 1ps

// Output register: load a result when free, hold it while the receiver stalls.
module rra_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             emit,
	input  rra_pkg::result_t res,
	output logic             free,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [39:0]      m_axis_tdata, // slot_id[3:0], block_address[35:4], notify[36]
	output logic [2:0]       m_axis_tuser, // kind
	output logic             m_axis_tlast
);

	logic             valid_q;
	rra_pkg::result_t res_q;

	assign free = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {3'b000, res_q.notify, res_q.addr, res_q.slot};
	assign m_axis_tuser  = res_q.kind;
	assign m_axis_tlast  = res_q.last;

endmodule

// ----- rtl/core/rra_checker.sv -----
`timescale 1ns / 1ps

module rra_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic [2:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
		$stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser <= rra_pkg::KIND_DONE)
		else $error("unknown result kind");

	// only purge notices may be followed by more results of the same item
	a_final: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != rra_pkg::KIND_PURGE |-> m_axis_tlast)
		else $error("closing result without tlast");

	a_fail: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == rra_pkg::KIND_FAIL |-> m_axis_tdata == 40'd0)
		else $error("failed allocate carries data");

	// hold off new items while the current one still has results to produce
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("input ready while an item is unfinished");

endmodule

bind ring_region_allocator rra_checker u_rra_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

// ----- tb/ring_region_allocator_tb.sv -----
`timescale 1ns / 1ps

module ring_region_allocator_tb;

	localparam int NSLOT = 16;
	// Longest allocate: a full flush of every slot plus setup.
	localparam int SETTLE_CYCLES = 80;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;   // request_size[31:0], slot_number[35:32]
	logic [1:0]  s_axis_tuser;   // command
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;   // slot_id[3:0], block_address[35:4], notify[36]
	logic [2:0]  m_axis_tuser;   // kind
	logic        m_axis_tlast;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	ring_region_allocator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#400000;
		$display("Simulation FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// Allocator shadow: configuration, slot table and ring pointers
	// ------------------------------------------------------------------
	longint unsigned cur_start, cur_end;
	int unsigned     cur_align, cur_bshift;
	bit              cur_ben;
	longint unsigned sh_base[NSLOT];
	longint unsigned sh_len[NSLOT];
	bit              sh_notify[NSLOT];
	bit              sh_written[NSLOT];   // entry holds a defined value in the block's memory
	int unsigned     ring_oldest, ring_newest, ring_live;

	rra_pkg::result_t expected_q[$];   // results still owed by the block, oldest first
	int      n_errors, n_items, n_results, n_allocs, n_purges, n_fails;
	bit      steady;           // suppress random idling on both sides

	task automatic report(input string what);
		n_errors++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	function automatic void owe(rra_pkg::kind_t k, int unsigned s, longint unsigned a, bit n);
		rra_pkg::result_t r;
		r.kind   = k;
		r.slot   = s[3:0];
		r.addr   = a[31:0];
		r.notify = n;
		r.last   = 1'b0;
		expected_q.push_back(r);
	endfunction

	function automatic void evict_oldest_block();
		int unsigned s;
		if (ring_live == 0)
			return;
		s = ring_oldest;
		owe(rra_pkg::KIND_PURGE, s, sh_base[s], sh_notify[s]);
		sh_base[s]    = 0;
		sh_len[s]     = 0;
		sh_notify[s]  = 0;
		sh_written[s] = 1;
		ring_live--;
		if (ring_live == 0) begin
			ring_oldest = 0;
			ring_newest = 0;
		end else begin
			ring_oldest = (s + 1) % NSLOT;
		end
	endfunction

	function automatic void place_block(longint unsigned req);
		longint unsigned amask, lo, sz, addr, b, m;
		int unsigned idx;
		amask = (64'd1 << cur_align) - 1;
		lo = cur_start;
		sz = req;
		if (lo & amask)
			lo = (lo | amask) + 1;
		if (sz & amask)
			sz = (sz | amask) + 1;
		if (sz == 0 || lo > 64'hFFFF_FFFF || lo >= cur_end || sz > cur_end - lo) begin
			owe(rra_pkg::KIND_FAIL, 0, 0, 0);
			return;
		end
		// Full table: flush everything first.
		if (ring_live >= NSLOT)
			while (ring_live > 0)
				evict_oldest_block();
		if (ring_live > 0) begin
			idx  = (ring_newest + 1) % NSLOT;
			addr = sh_base[ring_newest] + sh_len[ring_newest];
		end else begin
			idx  = 0;
			addr = lo;
		end
		// Move once to the next boundary if the block would straddle one.
		if (cur_ben) begin
			b = 64'd1 << cur_bshift;
			m = ~(b - 1);
			if ((addr & m) != ((addr + sz - 1) & m))
				addr = (addr & m) + b;
		end
		if (ring_live > 0) begin
			if (addr + sz > cur_end) begin
				while (ring_live > 0 && sh_base[ring_oldest] > addr)
					evict_oldest_block();
				addr = lo;
			end
		end else begin
			addr = lo;
		end
		while (ring_live > 0 && addr <= sh_base[ring_oldest] &&
		       addr + sz >= sh_base[ring_oldest])
			evict_oldest_block();
		sh_base[idx]    = addr & 64'hFFFF_FFFF;
		sh_len[idx]     = sz & 64'hFFFF_FFFF;
		sh_notify[idx]  = 1;
		sh_written[idx] = 1;
		if (ring_live == 0)
			ring_oldest = idx;
		ring_newest = idx;
		ring_live++;
		owe(rra_pkg::KIND_ALLOC, idx, addr, 0);
	endfunction

	// Queue up every result that one item causes; tag the final one.
	function automatic void predict_item(rra_pkg::cmd_t cmd, logic [31:0] size,
	                                     logic [3:0] slot);
		int n_prior;
		n_prior = expected_q.size();
		case (cmd)
			rra_pkg::CMD_ALLOC: place_block(size);
			rra_pkg::CMD_FLUSH: begin
				while (ring_live > 0)
					evict_oldest_block();
				owe(rra_pkg::KIND_DONE, 0, 0, 0);
			end
			rra_pkg::CMD_RELEASE: begin
				owe(rra_pkg::KIND_PURGE, slot, sh_base[slot], sh_notify[slot]);
				sh_notify[slot] = 0;
			end
			default: owe(rra_pkg::KIND_REPLY, slot, sh_base[slot], 0);
		endcase
		if (expected_q.size() > n_prior)
			expected_q[$].last = 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------
	function automatic bit idle_now();
		return !steady && ($urandom_range(99) < 8);
	endfunction

	// Hold the item until accepted; leave tvalid high so the next item can follow.
	task automatic send_item(input rra_pkg::cmd_t cmd, input logic [31:0] size,
	                         input logic [3:0] slot);
		while (idle_now()) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		predict_item(cmd, size, slot);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {4'd0, slot, size};
		do
			@(posedge clk);
		while (!s_axis_tready);
		n_items++;
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			rra_pkg::REG_START:    cur_start  = val;
			rra_pkg::REG_END:      cur_end    = val;
			rra_pkg::REG_ALIGN:    cur_align  = val[4:0];
			rra_pkg::REG_BOUNDARY: cur_bshift = val[4:0];
			rra_pkg::REG_BND_EN:   cur_ben    = val[0];
			default: begin
			end
		endcase
	endtask

	// Drain the block, then let any trailing work settle before touching registers.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_region(input logic [31:0] st, input logic [31:0] en,
	                          input logic [4:0] al, input logic [4:0] bs, input bit be);
		wait_idle();
		write_reg(rra_pkg::REG_START, st);
		write_reg(rra_pkg::REG_END, en);
		write_reg(rra_pkg::REG_ALIGN, {27'd0, al});
		write_reg(rra_pkg::REG_BOUNDARY, {27'd0, bs});
		write_reg(rra_pkg::REG_BND_EN, {31'd0, be});
	endtask

	// ------------------------------------------------------------------
	// Result monitor: random backpressure, compare against the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		rra_pkg::result_t want;
		m_axis_tready <= !idle_now();
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			n_results++;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result kind %0d", m_axis_tuser));
			end else begin
				want = expected_q.pop_front();
				if (m_axis_tuser != want.kind)
					report($sformatf("kind %0d, want %0d", m_axis_tuser, want.kind));
				if (m_axis_tdata[3:0] != want.slot)
					report($sformatf("slot %0d, want %0d", m_axis_tdata[3:0], want.slot));
				if (m_axis_tdata[35:4] != want.addr)
					report($sformatf("address %h, want %h", m_axis_tdata[35:4], want.addr));
				if (m_axis_tdata[36] != want.notify)
					report($sformatf("notify %b, want %b", m_axis_tdata[36], want.notify));
				if (m_axis_tlast != want.last)
					report($sformatf("last %b, want %b", m_axis_tlast, want.last));
				if (want.kind == rra_pkg::KIND_ALLOC) n_allocs++;
				if (want.kind == rra_pkg::KIND_PURGE) n_purges++;
				if (want.kind == rra_pkg::KIND_FAIL)  n_fails++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Directed rows: typed expectations only where obvious
	// ------------------------------------------------------------------
	typedef struct {
		rra_pkg::cmd_t  cmd;
		logic [31:0]    size;
		logic [3:0]     slot;
		int             reps;
		bit             typed;     // override the final result's kind and address
		rra_pkg::kind_t t_kind;
		logic [31:0]    t_addr;
	} row_t;

	row_t rows[] = '{
		'{rra_pkg::CMD_ALLOC,   32'd10,        4'd0,  1, 1, rra_pkg::KIND_ALLOC, 32'd0},
		'{rra_pkg::CMD_ALLOC,   32'd0,         4'd0,  1, 1, rra_pkg::KIND_FAIL,  32'd0},
		'{rra_pkg::CMD_ALLOC,   32'hFFFF_FFFF, 4'd15, 1, 1, rra_pkg::KIND_FAIL,  32'd0},
		'{rra_pkg::CMD_QUERY,   32'd0,         4'd0,  1, 1, rra_pkg::KIND_REPLY, 32'd0},
		'{rra_pkg::CMD_ALLOC,   32'd1,         4'd0,  1, 0, rra_pkg::KIND_ALLOC, 32'd0},
		'{rra_pkg::CMD_RELEASE, 32'd0,         4'd1,  1, 0, rra_pkg::KIND_PURGE, 32'd0},
		'{rra_pkg::CMD_RELEASE, 32'd0,         4'd1,  1, 0, rra_pkg::KIND_PURGE, 32'd0},
		'{rra_pkg::CMD_ALLOC,   32'h8000,      4'd0,  1, 0, rra_pkg::KIND_ALLOC, 32'd0},
		'{rra_pkg::CMD_ALLOC,   32'h8000,      4'd0,  1, 0, rra_pkg::KIND_ALLOC, 32'd0},
		'{rra_pkg::CMD_ALLOC,   32'h1_0000,    4'd0,  1, 0, rra_pkg::KIND_ALLOC, 32'd0},
		'{rra_pkg::CMD_QUERY,   32'd0,         4'd2,  1, 0, rra_pkg::KIND_REPLY, 32'd0},
		'{rra_pkg::CMD_FLUSH,   32'd0,         4'd0,  1, 1, rra_pkg::KIND_DONE,  32'd0},
		'{rra_pkg::CMD_FLUSH,   32'd0,         4'd0,  1, 1, rra_pkg::KIND_DONE,  32'd0},
		'{rra_pkg::CMD_QUERY,   32'd0,         4'd0,  1, 1, rra_pkg::KIND_REPLY, 32'd0},
		'{rra_pkg::CMD_ALLOC,   32'd4,         4'd0, 17, 0, rra_pkg::KIND_ALLOC, 32'd0},
		'{rra_pkg::CMD_RELEASE, 32'd0,         4'd15, 1, 0, rra_pkg::KIND_PURGE, 32'd0},
		'{rra_pkg::CMD_QUERY,   32'd0,         4'd15, 1, 0, rra_pkg::KIND_REPLY, 32'd0},
		'{rra_pkg::CMD_QUERY,   32'd0,         4'd0,  1, 0, rra_pkg::KIND_REPLY, 32'd0}
	};

	// For a release or query, pick a slot whose memory entry is defined; fall back to a flush if none is.
	task automatic random_item(input longint unsigned span);
		int unsigned pick, s, tries;
		logic [31:0] sz;
		pick = $urandom_range(99);
		sz = $urandom;
		if (pick < 70) begin
			if ($urandom_range(99) < 10)
				sz = $urandom;
			else if ($urandom_range(99) < 5)
				sz = 32'd1;
			else
				sz = $urandom_range(1, 32'((span / 3 > 1) ? span / 3 : 1));
			send_item(rra_pkg::CMD_ALLOC, sz, 4'($urandom_range(15)));
		end else if (pick < 80) begin
			send_item(rra_pkg::CMD_FLUSH, sz, 4'($urandom_range(15)));
		end else begin
			s = $urandom_range(15);
			tries = 0;
			while (!sh_written[s] && tries < 16) begin
				s = (s + 1) % NSLOT;
				tries++;
			end
			if (!sh_written[s])
				send_item(rra_pkg::CMD_FLUSH, sz, 4'd0);
			else
				send_item(pick < 90 ? rra_pkg::CMD_RELEASE : rra_pkg::CMD_QUERY, sz, s[3:0]);
		end
	endtask

	initial begin
		longint unsigned span;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= rra_pkg::CMD_ALLOC;
		cfg_we        <= 1'b0;
		cfg_index     <= rra_pkg::REG_START;
		cfg_data      <= '0;
		cur_start = 0; cur_end = 65536; cur_align = 2; cur_bshift = 20; cur_ben = 0;
		ring_oldest = 0; ring_newest = 0; ring_live = 0;
		foreach (sh_base[i]) begin
			sh_base[i] = 0; sh_len[i] = 0; sh_notify[i] = 0; sh_written[i] = 0;
		end
		n_errors = 0; n_items = 0; n_results = 0;
		n_allocs = 0; n_purges = 0; n_fails = 0;
		steady = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed walk at reset configuration.
		foreach (rows[r])
			for (int k = 0; k < rows[r].reps; k++) begin
				send_item(rows[r].cmd, rows[r].size, rows[r].slot);
				if (rows[r].typed) begin
					expected_q[$].kind = rows[r].t_kind;
					expected_q[$].addr = rows[r].t_addr;
				end
			end

		// Random phases, each under its own region setting.
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: set_region(32'd0, 32'd65536, 5'd2, 5'd20, 1'b0);
				1: set_region(32'h103, 32'h400, 5'd4, 5'd8, 1'b1);     // tight ring, lots of wraps
				2: set_region(32'd3, 32'h200, 5'd0, 5'd0, 1'b1);       // every multi-byte block moves
				3: set_region(32'd0, 32'hFFFF_FFFF, 5'd31, 5'd31, 1'b1); // widest alignment
				4: set_region(32'hFFFF_FFFF, 32'd0, 5'd0, 5'd31, 1'b0); // empty region
				5: set_region(32'd0, 32'hFFFF_FFFF, 5'd0, 5'd12, 1'b1);
				default: set_region($urandom, $urandom, 5'($urandom_range(8)),
				                    5'($urandom_range(31)), 1'($urandom_range(1)));
			endcase
			steady = (ph == 5);
			span = (cur_end > cur_start) ? cur_end - cur_start : 1;
			for (int i = 0; i < (ph == 4 ? 6 : 10); i++)
				random_item(span);
		end
		steady = 0;

		s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d items, %0d results: %0d allocations, %0d purge notices, %0d failures",
		         n_items, n_results, n_allocs, n_purges, n_fails);
		$display("Region settings swept: reset, tight wrap, unit boundary, 2^31 alignment, empty, random");
		if (n_errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
